### hw/rtl/m4ta_pkg.sv
package m4ta_pkg;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;
  localparam int DEPTH  = 16;
  localparam int PROD_W = 64;
  localparam int ACC_W  = 66;

  typedef enum logic [2:0] {
    CMD_IDENT = 3'd0,
    CMD_TRANS = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_MUL   = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_IDENT,
    ST_WRITE,
    ST_READ,
    ST_READ_W,
    ST_LOAD,
    ST_MAC,
    ST_DONE
  } state_t;

endpackage

### hw/rtl/m4ta_if.sv
interface m4ta_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [1:0]         col;
  logic [1:0]         row;
  logic signed [31:0] elem_value;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;

  modport source (output valid, cmd, col, row, elem_value, vec_x, vec_y, vec_z,
                  input ready);
  modport sink   (input valid, cmd, col, row, elem_value, vec_x, vec_y, vec_z,
                  output ready);
endinterface

interface m4ta_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic               saturated;

  modport source (output valid, read_value, saturated, input ready);
  modport sink   (input valid, read_value, saturated, output ready);
endinterface

### hw/rtl/m4ta_ram.sv
module m4ta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/matrix4_transform_accumulator.sv
// Throughput: one command at a time; multiply is bound by one shared 32x32 multiplier
// fed from one read port of each matrix RAM (one product per cycle, four per element).
// Reset: synchronous, active low; a clearing pass over the 16 words loads identity into
// the current matrix and zeros into the operand store, during which no beat is accepted.
module matrix4_transform_accumulator
  import m4ta_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  m4ta_in_if.sink   in_bus,
  m4ta_out_if.source out_bus
);

  localparam logic signed [DATA_W-1:0] ONE_FIX = DATA_W'(1) << FRAC_BITS;

  state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [1:0] r_r, c_r;
  cmd_t       cmd_r;
  logic [1:0] col_r, row_r;
  logic signed [DATA_W-1:0] elem_r, vx_r, vy_r, vz_r;
  logic signed [DATA_W-1:0] rowq_r [4];
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic       sat_r;
  logic signed [DATA_W-1:0] res_val_r;
  logic       out_valid_r;
  logic signed [DATA_W-1:0] out_val_r;
  logic       out_sat_r;

  // RAM ports
  logic              cur_we, op_we;
  logic [ADDR_W-1:0] cur_waddr, cur_raddr, op_waddr, op_raddr;
  logic [DATA_W-1:0] cur_wdata, op_wdata, cur_rdata, op_rdata;

  logic       in_acc;
  logic       mac_end;
  logic       last_elem;
  logic [1:0] k_idx;
  logic signed [DATA_W-1:0] b_sel;
  logic signed [ACC_W-1:0]  shifted;
  logic       ovf;
  logic signed [DATA_W-1:0] sat_val;

  assign in_acc    = in_bus.valid && in_bus.ready;
  assign mac_end   = (state_r == ST_MAC) && (cnt_r == 4'd6);
  assign last_elem = (r_r == 2'd3) && ((cmd_r == CMD_TRANS) || (c_r == 2'd3));
  // k of the operand word that arrived this cycle
  assign k_idx     = cnt_r[1:0] - 2'd1;

  // Scale down by floor and clip to 32 bits
  assign shifted = acc_r >>> FRAC_BITS;
  assign ovf     = !((&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]));
  assign sat_val = ovf ? (shifted[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                           : {1'b0, {(DATA_W-1){1'b1}}})
                       : shifted[DATA_W-1:0];

  // Translate is a dot product of the row with (x, y, z, 1.0)
  always_comb begin
    b_sel = op_rdata;
    if (cmd_r == CMD_TRANS) begin
      case (k_idx)
        2'd0:    b_sel = vx_r;
        2'd1:    b_sel = vy_r;
        2'd2:    b_sel = vz_r;
        default: b_sel = ONE_FIX;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (cnt_r == 4'd15) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_t'(in_bus.cmd))
            CMD_IDENT: state_nxt = ST_IDENT;
            CMD_TRANS: state_nxt = ST_LOAD;
            CMD_WRITE: state_nxt = ST_WRITE;
            CMD_MUL:   state_nxt = ST_LOAD;
            CMD_READ:  state_nxt = ST_READ;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_IDENT:  if (cnt_r == 4'd15) state_nxt = ST_DONE;
      ST_WRITE:  state_nxt = ST_DONE;
      ST_READ:   state_nxt = ST_READ_W;
      ST_READ_W: state_nxt = ST_DONE;
      ST_LOAD:   if (cnt_r == 4'd4) state_nxt = ST_MAC;
      ST_MAC: begin
        if (mac_end) begin
          if (last_elem) begin
            state_nxt = ST_DONE;
          end else if ((cmd_r == CMD_TRANS) || (c_r == 2'd3)) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_DONE:   if (!out_valid_r || out_bus.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  assign cnt_nxt = ((state_nxt != state_r) || mac_end) ? 4'd0 : cnt_r + 4'd1;

  // Outputs: RAM control and handshake
  always_comb begin
    cur_we    = 1'b0;
    cur_waddr = cnt_r;
    cur_wdata = '0;
    cur_raddr = {col_r, row_r};
    op_we     = 1'b0;
    op_waddr  = cnt_r;
    op_wdata  = '0;
    op_raddr  = {c_r, cnt_r[1:0]};
    case (state_r)
      ST_CLEAR: begin
        cur_we    = 1'b1;
        cur_wdata = (cnt_r[3:2] == cnt_r[1:0]) ? ONE_FIX : '0;
        op_we     = 1'b1;
      end
      ST_IDENT: begin
        cur_we    = 1'b1;
        cur_wdata = (cnt_r[3:2] == cnt_r[1:0]) ? ONE_FIX : '0;
      end
      ST_WRITE: begin
        op_we    = 1'b1;
        op_waddr = {col_r, row_r};
        op_wdata = elem_r;
      end
      ST_LOAD: cur_raddr = {cnt_r[1:0], r_r};
      ST_MAC: begin
        cur_we    = mac_end;
        cur_waddr = {c_r, r_r};
        cur_wdata = sat_val;
      end
      default: ;
    endcase
  end

  assign in_bus.ready       = (state_r == ST_IDLE);
  assign out_bus.valid      = out_valid_r;
  assign out_bus.read_value = out_val_r;
  assign out_bus.saturated  = out_sat_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if ((state_r == ST_DONE) && (state_nxt == ST_IDLE)) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r     <= cmd_t'(in_bus.cmd);
      col_r     <= in_bus.col;
      row_r     <= in_bus.row;
      elem_r    <= in_bus.elem_value;
      vx_r      <= in_bus.vec_x;
      vy_r      <= in_bus.vec_y;
      vz_r      <= in_bus.vec_z;
      r_r       <= 2'd0;
      c_r       <= (cmd_t'(in_bus.cmd) == CMD_TRANS) ? 2'd3 : 2'd0;
      sat_r     <= 1'b0;
      res_val_r <= '0;
    end
    // hold the old row while its new elements are written back
    if ((state_r == ST_LOAD) && (cnt_r != 4'd0)) begin
      rowq_r[k_idx] <= cur_rdata;
    end
    if (state_r == ST_MAC) begin
      if ((cnt_r >= 4'd1) && (cnt_r <= 4'd4)) begin
        prod_r <= PROD_W'(rowq_r[k_idx]) * PROD_W'(b_sel);
      end
      if (cnt_r == 4'd1) begin
        acc_r <= '0;
      end else if ((cnt_r >= 4'd2) && (cnt_r <= 4'd5)) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
      if (mac_end) begin
        sat_r <= sat_r | ovf;
        if ((cmd_r == CMD_TRANS) || (c_r == 2'd3)) begin
          r_r <= r_r + 2'd1;
          if (cmd_r != CMD_TRANS) c_r <= 2'd0;
        end else begin
          c_r <= c_r + 2'd1;
        end
      end
    end
    if (state_r == ST_READ_W) begin
      res_val_r <= cur_rdata;
    end
    if ((state_r == ST_DONE) && (state_nxt == ST_IDLE)) begin
      out_val_r <= res_val_r;
      out_sat_r <= sat_r;
    end
  end

  m4ta_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .raddr (cur_raddr),
    .rdata (cur_rdata)
  );

  m4ta_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_op_ram (
    .clk   (clk),
    .we    (op_we),
    .waddr (op_waddr),
    .wdata (op_wdata),
    .raddr (op_raddr),
    .rdata (op_rdata)
  );

endmodule
